// ----- hw/rtl/psbp_pkg.sv -----
`timescale 1ns / 1ps

package psbp_pkg;

    localparam int MODE_W      = 2;
    localparam int PDU_W       = 4;
    localparam int START_W     = 9;
    localparam int LEN_W       = 7;
    localparam int RAW_W       = 64;
    localparam int BIDX_W      = 6;
    localparam int BYTE_W      = 8;
    localparam int OFF_W       = 6;
    localparam int WORD_W      = 64;
    localparam int WIN_W       = 2 * WORD_W;
    localparam int S_TDATA_W   = 104;
    localparam int M_TDATA_W   = 72;
    localparam int S_TUSER_W   = MODE_W;
    localparam int M_TUSER_W   = 1;
    localparam int MAX_SIG_BITS = 64;
    localparam int BITS_PER_BYTE = 8;

    localparam logic [MODE_W-1:0] MODE_PACK    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UNPACK  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WR_BYTE = 2'd2;
    localparam logic [MODE_W-1:0] MODE_RD_BYTE = 2'd3;

    localparam logic [BYTE_W-1:0] BYTE_MASK = 8'hff;

    typedef struct packed {
        logic accept;
        logic clr_wr;
        logic rd_lo;
        logic rd_hi;
        logic calc;
        logic wr_lo;
        logic wr_hi;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic err;
        logic is_write;
        logic out_free;
    } t_stat;

endpackage

// ----- hw/rtl/psbp_ram.sv -----
`timescale 1ns / 1ps

module psbp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 129
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/psbp_ctrl.sv -----
`timescale 1ns / 1ps

module psbp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  psbp_pkg::t_stat i_stat,
    output logic            o_ready,
    output psbp_pkg::t_cmd  o_cmd
);

    import psbp_pkg::*;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RD0  = 3'd2;
    localparam logic [2:0] S_RD1  = 3'd3;
    localparam logic [2:0] S_CALC = 3'd4;
    localparam logic [2:0] S_WR0  = 3'd5;
    localparam logic [2:0] S_WR1  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_cmd       cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        o_ready = 1'b0;
        case (r_state)
            S_CLR: begin
                cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready    = 1'b1;
                cmd.accept = i_valid;
                if (i_valid) begin
                    n_state = S_RD0;
                end
            end
            S_RD0: begin
                if (i_stat.err) begin
                    n_state = S_DONE;
                end else begin
                    cmd.rd_lo = 1'b1;
                    n_state   = S_RD1;
                end
            end
            S_RD1: begin
                cmd.rd_hi = 1'b1;
                n_state   = S_CALC;
            end
            S_CALC: begin
                cmd.calc = 1'b1;
                n_state  = i_stat.is_write ? S_WR0 : S_DONE;
            end
            S_WR0: begin
                cmd.wr_lo = 1'b1;
                n_state   = S_WR1;
            end
            S_WR1: begin
                cmd.wr_hi = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

    assign o_cmd = cmd;

endmodule

// ----- hw/rtl/psbp_dpath.sv -----
`timescale 1ns / 1ps

module psbp_dpath #(
    parameter int NUM_PDUS      = 16,
    parameter int PAYLOAD_BYTES = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  psbp_pkg::t_cmd                      i_cmd,
    input  logic [psbp_pkg::S_TDATA_W-1:0]      i_s_tdata,
    input  logic [psbp_pkg::S_TUSER_W-1:0]      i_s_tuser,
    input  logic                                i_m_tready,
    output psbp_pkg::t_stat                     o_stat,
    output logic                                o_m_tvalid,
    output logic [psbp_pkg::M_TDATA_W-1:0]      o_m_tdata,
    output logic [psbp_pkg::M_TUSER_W-1:0]      o_m_tuser
);

    import psbp_pkg::*;

    localparam int STORE_BYTES = NUM_PDUS * PAYLOAD_BYTES;
    localparam int DEPTH       = (STORE_BYTES + 7) / 8 + 1;
    localparam int AW          = $clog2(DEPTH);
    localparam int GW          = $clog2(STORE_BYTES + 64);

    // request fields
    logic [MODE_W-1:0]  in_mode;
    logic [PDU_W-1:0]   in_pdu;
    logic [START_W-1:0] in_start;
    logic [LEN_W-1:0]   in_len;
    logic [RAW_W-1:0]   in_raw;
    logic [BIDX_W-1:0]  in_bidx;
    logic [BYTE_W-1:0]  in_bval;

    assign in_mode  = i_s_tuser;
    assign in_pdu   = i_s_tdata[3:0];
    assign in_start = i_s_tdata[12:4];
    assign in_len   = i_s_tdata[19:13];
    assign in_raw   = i_s_tdata[83:20];
    assign in_bidx  = i_s_tdata[89:84];
    assign in_bval  = i_s_tdata[97:90];

    logic [GW-1:0] base_byte;
    logic [GW-1:0] g_byte;
    logic          is_sig;
    logic          pdu_bad;
    logic          sig_bad;
    logic          byte_bad;
    logic [11:0]   field_end;

    assign is_sig    = in_mode inside {MODE_PACK, MODE_UNPACK};
    assign base_byte = GW'(32'(in_pdu) * 32'(PAYLOAD_BYTES));
    assign g_byte    = base_byte + (is_sig ? GW'(in_start[START_W-1:3]) : GW'(in_bidx));
    assign pdu_bad   = {5'd0, in_pdu} >= 9'(NUM_PDUS);
    assign field_end = 12'(in_start) + 12'(in_len);
    assign sig_bad   = (in_len > 7'(MAX_SIG_BITS))
                    || (field_end > 12'(BITS_PER_BYTE * PAYLOAD_BYTES));
    assign byte_bad  = {3'd0, in_bidx} >= 9'(PAYLOAD_BYTES);

    // item registers
    logic [MODE_W-1:0] r_mode;
    logic              r_err;
    logic [AW-1:0]     r_wa;
    logic [OFF_W-1:0]  r_off;
    logic [LEN_W-1:0]  r_len;
    logic [RAW_W-1:0]  r_val;
    logic [WORD_W-1:0] r_lo;
    logic [WIN_W-1:0]  r_win;
    logic [RAW_W-1:0]  r_raw_res;
    logic [BYTE_W-1:0] r_byte_res;
    logic [AW-1:0]     r_clr_cnt;
    logic [AW-1:0]     wa_hi;

    assign wa_hi = r_wa + AW'(1);

    // field extract and merge over two words
    logic [WORD_W-1:0] ram_rdata;
    logic [WIN_W-1:0]  win;
    logic [WIN_W-1:0]  shifted;
    logic [RAW_W-1:0]  mask;
    logic [RAW_W-1:0]  field;
    logic [WIN_W-1:0]  mask_w;
    logic [WIN_W-1:0]  data_w;
    logic [WIN_W-1:0]  new_win;

    assign win     = {ram_rdata, r_lo};
    assign shifted = win >> r_off;
    assign mask    = r_len[6] ? '1 : ((RAW_W'(1) << r_len[5:0]) - RAW_W'(1));
    assign field   = shifted[RAW_W-1:0] & mask;
    assign mask_w  = {{(WIN_W - RAW_W){1'b0}}, mask} << r_off;
    assign data_w  = {{(WIN_W - RAW_W){1'b0}}, r_val & mask} << r_off;
    assign new_win = (win & ~mask_w) | data_w;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode     <= in_mode;
            r_err      <= pdu_bad | (is_sig ? sig_bad : byte_bad);
            r_wa       <= g_byte[3 +: AW];
            r_off      <= is_sig ? {g_byte[2:0], in_start[2:0]} : {g_byte[2:0], 3'd0};
            r_len      <= is_sig ? in_len : LEN_W'(BITS_PER_BYTE);
            r_val      <= is_sig ? in_raw : {{(RAW_W - BYTE_W){1'b0}}, in_bval};
            r_raw_res  <= '0;
            r_byte_res <= '0;
        end
        if (i_cmd.rd_hi) begin
            r_lo <= ram_rdata;
        end
        if (i_cmd.calc) begin
            r_win      <= new_win;
            r_raw_res  <= (r_mode == MODE_UNPACK) ? field : '0;
            r_byte_res <= (r_mode == MODE_RD_BYTE) ? (field[BYTE_W-1:0] & BYTE_MASK) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_cnt <= r_clr_cnt + AW'(1);
        end
    end

    // payload memory
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;

    assign ram_we    = i_cmd.clr_wr | i_cmd.wr_lo | i_cmd.wr_hi;
    assign ram_waddr = i_cmd.clr_wr ? r_clr_cnt : (i_cmd.wr_hi ? wa_hi : r_wa);
    assign ram_wdata = i_cmd.clr_wr ? '0
                     : (i_cmd.wr_hi ? r_win[WIN_W-1:WORD_W] : r_win[WORD_W-1:0]);
    assign ram_raddr = i_cmd.rd_hi ? wa_hi : r_wa;

    psbp_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // output register
    logic              r_m_valid;
    logic [RAW_W-1:0]  r_m_raw;
    logic [BYTE_W-1:0] r_m_byte;
    logic              r_m_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_m_raw  <= r_err ? '0 : r_raw_res;
            r_m_byte <= r_err ? '0 : r_byte_res;
            r_m_err  <= r_err;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {r_m_byte, r_m_raw};
    assign o_m_tuser  = r_m_err;

    assign o_stat.clr_last = (r_clr_cnt == AW'(DEPTH - 1));
    assign o_stat.err      = r_err;
    assign o_stat.is_write = r_mode inside {MODE_PACK, MODE_WR_BYTE};
    assign o_stat.out_free = !r_m_valid || i_m_tready;

endmodule

// ----- hw/rtl/pdu_signal_bit_packer.sv -----
`timescale 1ns / 1ps

// channel   dir  handshake                 payload
// request   in   i_s_tvalid / o_s_tready   i_s_tdata, i_s_tuser (mode)
// result    out  o_m_tvalid / i_m_tready   o_m_tdata, o_m_tuser (range_error)
//
// a signal or byte request passes read low, read high and calc steps (then, for writes,
// write low and write high) to done: two word reads and, for writes, two word writes
// of the 64-bit payload memory; after reset the memory is swept to zero, one word a
// cycle, while o_s_tready stays low
// a rejected request skips the reads and goes straight to done; a stalled result holds
// the next request in its final step until the result register frees

module pdu_signal_bit_packer #(
    parameter int NUM_PDUS      = 16,
    parameter int PAYLOAD_BYTES = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // pdu_index, start_pos, sig_len, raw_value, byte_index, byte_value
    input  logic [psbp_pkg::S_TDATA_W-1:0]      i_s_tdata,
    // mode
    input  logic [psbp_pkg::S_TUSER_W-1:0]      i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // raw_out, byte_out
    output logic [psbp_pkg::M_TDATA_W-1:0]      o_m_tdata,
    // range_error
    output logic [psbp_pkg::M_TUSER_W-1:0]      o_m_tuser
);

    import psbp_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    psbp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_stat  (stat),
        .o_ready (o_s_tready),
        .o_cmd   (cmd)
    );

    psbp_dpath #(
        .NUM_PDUS      (NUM_PDUS),
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_m_tready (i_m_tready),
        .o_stat     (stat),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request taken while busy");

    a_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.accept, cmd.clr_wr, cmd.rd_lo, cmd.rd_hi, cmd.calc,
                  cmd.wr_lo, cmd.wr_hi, cmd.out_load}))
        else $error("overlapping controller steps");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_m_tvalid || i_m_tready))
        else $error("result overwritten before taken");

    a_result_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && i_m_tready && !cmd.out_load) |=> !o_m_tvalid)
        else $error("result repeated");

endmodule
